/* sv/atm_pkg.sv */
// ----------------------------------------------------------------------------
// atm_pkg: shared types and constants of the alpha-trimmed mean filter
// Holds the default sizes, the register indexes, the reset values and the
// state types of the controller and of the trim unit.
// ----------------------------------------------------------------------------
`default_nettype none

package atm_pkg;

  // Default sizes; the first two are handed down as parameter defaults.
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_WINDOW    = 5;
  localparam int MAX_HEIGHT    = 1024;

  // Configuration port.
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_DISCARD_COUNT = 2'd2
  } cfg_idx_t;

  localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [10:0] RST_IMAGE_HEIGHT  = 11'd480;
  localparam logic [3:0]  RST_DISCARD_COUNT = 4'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_PUT
  } ctrl_state_t;

  // Trim unit states.
  typedef enum logic [1:0] {
    TR_IDLE,
    TR_RANK,
    TR_DIV
  } trim_state_t;

  // Request from the controller to the trim unit.
  typedef struct packed {
    logic       start;
    logic       bypass;
    logic [2:0] half;
  } trim_req_t;

endpackage

`default_nettype wire

/* sv/atm_ram.sv */
// ----------------------------------------------------------------------------
// atm_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module atm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/atm_trim.sv */
// ----------------------------------------------------------------------------
// atm_trim: rank-based trimmed sum and iterative divider
// Ranks one window value per cycle, sums the values whose stable rank lies
// inside the kept range, then divides by the kept count one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module atm_trim #(
  parameter int WINDOW = atm_pkg::DEF_WINDOW
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire atm_pkg::trim_req_t                   req,
  input  wire logic [WINDOW*WINDOW-1:0][7:0]        win,
  output logic                                      done,
  output logic [7:0]                                result
);

  import atm_pkg::*;

  localparam int TAPS   = WINDOW * WINDOW;
  localparam int CENTER = (WINDOW / 2) * WINDOW + WINDOW / 2;
  localparam int IW     = $clog2(TAPS);
  localparam int CNT_W  = $clog2(TAPS + 1);
  localparam int SUM_W  = $clog2(TAPS * 255 + 1);
  localparam int BC_W   = $clog2(SUM_W);

  trim_state_t      state_r, state_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] quot_r, quot_nxt;
  logic [CNT_W:0]   rem_r, rem_nxt;
  logic [BC_W-1:0]  bit_r, bit_nxt;
  logic [2:0]       half_r, half_nxt;
  logic [7:0]       result_r, result_nxt;
  logic             done_r, done_nxt;

  logic [7:0]       key;
  logic [TAPS-1:0]  below;
  logic [CNT_W-1:0] rank;
  logic [CNT_W-1:0] keep_hi;
  logic [CNT_W-1:0] divisor;
  logic [CNT_W:0]   rem_sh;
  logic             kept;

  // Stable rank of the selected value: smaller values plus equal ones before it.
  always_comb begin
    key = win[idx_r];
    for (int j = 0; j < TAPS; j++) begin
      below[j] = (win[j] < key) || ((win[j] == key) && (IW'(j) < idx_r));
    end
    rank    = CNT_W'($countones(below));
    keep_hi = CNT_W'(TAPS) - CNT_W'(half_r);
    kept    = (rank >= CNT_W'(half_r)) && (rank < keep_hi);
    divisor = CNT_W'(TAPS) - CNT_W'({half_r, 1'b0});
    rem_sh  = {rem_r[CNT_W-1:0], quot_r[SUM_W-1]};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TR_IDLE: begin
        if (req.start && !req.bypass) begin
          state_nxt = TR_RANK;
        end
      end
      TR_RANK: begin
        if (idx_r == IW'(TAPS - 1)) begin
          state_nxt = TR_DIV;
        end
      end
      TR_DIV: begin
        if (bit_r == '0) begin
          state_nxt = TR_IDLE;
        end
      end
      default: state_nxt = TR_IDLE;
    endcase
  end

  // Datapath.
  always_comb begin
    idx_nxt    = idx_r;
    sum_nxt    = sum_r;
    quot_nxt   = quot_r;
    rem_nxt    = rem_r;
    bit_nxt    = bit_r;
    half_nxt   = half_r;
    result_nxt = result_r;
    done_nxt   = 1'b0;
    case (state_r)
      TR_IDLE: begin
        if (req.start) begin
          if (req.bypass) begin
            result_nxt = win[CENTER];
            done_nxt   = 1'b1;
          end else begin
            idx_nxt  = '0;
            sum_nxt  = '0;
            half_nxt = req.half;
          end
        end
      end
      TR_RANK: begin
        if (kept) begin
          sum_nxt = sum_r + SUM_W'(key);
        end
        idx_nxt = idx_r + IW'(1);
        if (idx_r == IW'(TAPS - 1)) begin
          quot_nxt = kept ? sum_r + SUM_W'(key) : sum_r;
          rem_nxt  = '0;
          bit_nxt  = BC_W'(SUM_W - 1);
        end
      end
      TR_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_sh >= {1'b0, divisor}) begin
          rem_nxt  = rem_sh - {1'b0, divisor};
          quot_nxt = {quot_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          quot_nxt = {quot_r[SUM_W-2:0], 1'b0};
        end
        bit_nxt = bit_r - BC_W'(1);
        if (bit_r == '0) begin
          result_nxt = quot_nxt[7:0];
          done_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TR_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    sum_r    <= sum_nxt;
    quot_r   <= quot_nxt;
    rem_r    <= rem_nxt;
    bit_r    <= bit_nxt;
    half_r   <= half_nxt;
    result_r <= result_nxt;
  end

  assign done   = done_r;
  assign result = result_r;

  // The remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == TR_DIV) |-> (rem_r < {1'b0, divisor}))
    else $error("divider remainder out of range");

  // A new request never arrives while a computation runs.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != TR_IDLE) |-> !req.start)
    else $error("trim request while busy");

  // Completion comes from the last divide step or from a bypass request.
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(state_r) == TR_DIV) || $past(req.start && req.bypass))
    else $error("spurious trim completion");

endmodule

`default_nettype wire

/* sv/alpha_trimmed_mean_filter_5x5_unit.sv */
// ----------------------------------------------------------------------------
// alpha_trimmed_mean_filter_5x5_unit: streaming alpha-trimmed mean filter
// Line buffers in one RAM, a register window, and a shared trim unit.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in row-major order on the in_ channel (valid/ready). Each
//   request is a single 8-bit pixel. For every interior pixel one result
//   request leaves on the out_ channel with row, column, trimmed mean and a
//   frame end flag; border pixels produce no result.
//   One pixel is processed at a time. A border pixel takes a line RAM read
//   and then the write-back and window shift. An interior pixel then goes
//   on through ranking (one window value per cycle), division (one
//   quotient bit per cycle) and the hand-off; with trimming disabled the
//   rank and divide steps are skipped.
//   The result sits in an output register; a stalled receiver holds the
//   block after the next result is ready until the register is free.
//   Reset clears the position counters and loads the default sizes
//   (640 x 480, discard 2); line RAM and window contents are undefined
//   until written, so the first rows of a frame must be streamed in full.
//   Configuration writes are taken at any cycle via cfg_we.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_trimmed_mean_filter_5x5_unit #(
  parameter int MAX_WIDTH = atm_pkg::DEF_MAX_WIDTH,
  parameter int WINDOW    = atm_pkg::DEF_WINDOW
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [atm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [atm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_pixel,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [9:0]                         out_row,
  output logic [9:0]                         out_col,
  output logic [7:0]                         out_value,
  output logic                               out_frame_end
);

  import atm_pkg::*;

  localparam int TAPS  = WINDOW * WINDOW;
  localparam int LINES = WINDOW - 1;
  localparam int RAD   = WINDOW / 2;
  localparam int MID   = (TAPS - 1) / 2;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int UW    = (AW + 1 > 11) ? AW + 1 : 11;

  // Configuration registers.
  logic [10:0] width_cfg_r;
  logic [10:0] height_cfg_r;
  logic [3:0]  discard_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= RST_IMAGE_WIDTH;
      height_cfg_r <= RST_IMAGE_HEIGHT;
      discard_r    <= RST_DISCARD_COUNT;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:   width_cfg_r  <= cfg_wdata[10:0];
        CFG_IMAGE_HEIGHT:  height_cfg_r <= cfg_wdata[10:0];
        CFG_DISCARD_COUNT: discard_r    <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  ctrl_state_t state_r, state_nxt;
  logic [AW-1:0] col_r, col_nxt;
  logic [9:0]    row_r, row_nxt;

  logic [7:0]    px_r;
  logic [AW-1:0] addr_r;
  logic          emit_r;
  logic [9:0]    prow_r, pcol_r;
  logic          pend_r;

  logic [TAPS-1:0][7:0] win_r;
  logic [TAPS-1:0][7:0] win_nxt;

  logic [LINES*8-1:0] ram_rdata;
  logic [LINES*8-1:0] ram_wdata;
  logic               ram_we;

  logic          accept;
  logic [UW-1:0] uw, c_ext, c_inc;
  logic [10:0]   uh, r_ext, r_inc;
  logic          emit, fend;

  trim_req_t     treq;
  logic          tdone;
  logic [7:0]    tresult;

  logic          out_valid_r;
  logic [9:0]    out_row_r, out_col_r;
  logic [7:0]    out_value_r;
  logic          out_fend_r;

  assign accept = in_valid && in_ready;

  // Sizes in use, saturated, and position bookkeeping.
  always_comb begin
    uw = UW'(width_cfg_r);
    if (uw < UW'(WINDOW)) begin
      uw = UW'(WINDOW);
    end else if (uw > UW'(MAX_WIDTH)) begin
      uw = UW'(MAX_WIDTH);
    end
    uh = height_cfg_r;
    if (uh < 11'(WINDOW)) begin
      uh = 11'(WINDOW);
    end else if (uh > 11'(MAX_HEIGHT)) begin
      uh = 11'(MAX_HEIGHT);
    end
    c_ext = UW'(col_r);
    c_inc = c_ext + UW'(1);
    r_ext = 11'(row_r);
    r_inc = r_ext + 11'd1;
    emit  = (r_ext >= 11'(2 * RAD)) && (c_ext >= UW'(2 * RAD)) &&
            (r_ext < uh) && (c_ext < uw);
    fend  = (r_inc == uh) && (c_inc == uw);
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (c_inc >= uw) begin
        col_nxt = '0;
        row_nxt = (r_inc >= uh) ? 10'd0 : r_inc[9:0];
      end else begin
        col_nxt = c_inc[AW-1:0];
      end
    end
  end

  // Line store: one word per column holding the previous rows, newest low.
  atm_ram #(
    .WIDTH (LINES * 8),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign ram_wdata = {ram_rdata[(LINES-1)*8-1:0], px_r};

  // Window shift with the new column from the line store and the pixel.
  always_comb begin
    win_nxt = win_r;
    if (state_r == ST_LOAD) begin
      for (int y = 0; y < WINDOW; y++) begin
        for (int x = 0; x < WINDOW - 1; x++) begin
          win_nxt[y*WINDOW+x] = win_r[y*WINDOW+x+1];
        end
      end
      for (int y = 0; y < LINES; y++) begin
        win_nxt[y*WINDOW+WINDOW-1] = ram_rdata[(LINES-1-y)*8 +: 8];
      end
      win_nxt[LINES*WINDOW+WINDOW-1] = px_r;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = emit_r ? ST_CALC : ST_IDLE;
      ST_CALC: if (tdone) state_nxt = ST_PUT;
      ST_PUT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready    = 1'b0;
    ram_we      = 1'b0;
    treq.start  = 1'b0;
    treq.bypass = (32'(discard_r) >= MID);
    treq.half   = discard_r[3:1];
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_LOAD: begin
        ram_we     = 1'b1;
        treq.start = emit_r;
      end
      default: ;
    endcase
  end

  atm_trim #(
    .WINDOW (WINDOW)
  ) u_trim (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (treq),
    .win    (win_nxt),
    .done   (tdone),
    .result (tresult)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (state_r == ST_PUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (accept) begin
      px_r   <= in_pixel;
      addr_r <= col_r;
      emit_r <= emit;
      prow_r <= 10'(r_ext - 11'(RAD));
      pcol_r <= 10'(c_ext - UW'(RAD));
      pend_r <= fend;
    end
    if (state_r == ST_PUT && (!out_valid_r || out_ready)) begin
      out_row_r   <= prow_r;
      out_col_r   <= pcol_r;
      out_value_r <= tresult;
      out_fend_r  <= pend_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign out_frame_end = out_fend_r;

  // Line store write-back follows the read of the same pixel.
  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> $past(accept))
    else $error("line store write without a preceding read");

  // A result becomes valid only out of the hand-off state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_PUT)
    else $error("result produced outside hand-off");

  // The trim unit completes only while the controller waits for it.
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    tdone |-> state_r == ST_CALC)
    else $error("trim completion while not waiting");

endmodule

`default_nettype wire
